// ===== rtl/ikv_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package ikv_pkg;

  localparam int unsigned BUF_BYTES = 65536;
  localparam int unsigned POS_W     = 16;
  localparam int unsigned CNT_W     = 17;
  localparam int unsigned BYTE_W    = 8;

  localparam int unsigned POS_LIMIT_INT = ((BUF_BYTES - 1) > 65535) ? 65535 : (BUF_BYTES - 1);
  localparam logic [POS_W-1:0] POS_LIMIT = POS_LIMIT_INT[POS_W-1:0];

  localparam logic [CNT_W-1:0] MAX_PAIRS_RST = 17'h10000;
  localparam logic [CNT_W-1:0] CNT_SAT       = 17'h1FFFF;

  localparam logic [BYTE_W-1:0] CH_LF   = 8'h0A;
  localparam logic [BYTE_W-1:0] CH_TAB  = 8'h09;
  localparam logic [BYTE_W-1:0] CH_VT   = 8'h0B;
  localparam logic [BYTE_W-1:0] CH_FF   = 8'h0C;
  localparam logic [BYTE_W-1:0] CH_CR   = 8'h0D;
  localparam logic [BYTE_W-1:0] CH_SP   = 8'h20;
  localparam logic [BYTE_W-1:0] CH_HASH = 8'h23;
  localparam logic [BYTE_W-1:0] CH_EQ   = 8'h3D;
  localparam logic [BYTE_W-1:0] CH_LBR  = 8'h5B;
  localparam logic [BYTE_W-1:0] CH_RBR  = 8'h5D;

  typedef enum logic [1:0] {
    KIND_PAIR  = 2'd0,
    KIND_NO_EQ = 2'd1,
    KIND_DROP  = 2'd2,
    KIND_END   = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    PH_START   = 2'd0,
    PH_COMMENT = 2'd1,
    PH_SECTION = 2'd2,
    PH_KV      = 2'd3
  } phase_e;

  function automatic logic is_blank(input logic [BYTE_W-1:0] c);
    return (c == CH_SP) || (c == CH_TAB) || (c == CH_LF) ||
           (c == CH_CR) || (c == CH_FF) || (c == CH_VT);
  endfunction

endpackage

`default_nettype wire

// ===== rtl/ikv_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

interface ikv_in_if import ikv_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] data_byte;
  logic              is_last;

  modport source (output valid, output data_byte, output is_last, input ready);
  modport sink   (input valid, input data_byte, input is_last, output ready);
endinterface

interface ikv_out_if import ikv_pkg::*; ();
  logic             valid;
  logic             ready;
  kind_e            kind;
  logic [POS_W-1:0] section_start;
  logic [POS_W-1:0] section_len;
  logic [POS_W-1:0] key_start;
  logic [POS_W-1:0] key_len;
  logic [POS_W-1:0] value_start;
  logic [POS_W-1:0] value_len;
  logic [CNT_W-1:0] pair_count;
  logic             is_final;
  logic             too_long;

  modport source (
    output valid, output kind, output section_start, output section_len,
    output key_start, output key_len, output value_start, output value_len,
    output pair_count, output is_final, output too_long, input ready
  );
  modport sink (
    input valid, input kind, input section_start, input section_len,
    input key_start, input key_len, input value_start, input value_len,
    input pair_count, input is_final, input too_long, output ready
  );
endinterface

`default_nettype wire

// ===== rtl/ini_key_value_line_parser.sv =====
`timescale 1ns / 1ps
`default_nettype none
// INI key/value line parser.
// in_i  : one byte of a text buffer per item, is_last marks the final byte.
// out_o : at most one result item per byte; a key/value line gives a pair,
//         a missing '=' or a dropped pair when the count reaches max_pairs,
//         and a buffer whose last line gives nothing closes with an end item.
// max_pairs_we_i / max_pairs_i : write the pair limit, only while idle.
// An accepted byte is held in the input register; it is then parsed against
// the line state and its result is loaded into the result register.
// Throughput: one byte per cycle while the receiver does not stall, set by
// the single pass of compare and subtract logic between the input register
// and the result register. When the receiver stalls, the result register
// holds its item; if the input register is empty, one more byte is taken
// into it, and in_i.ready then stays low until the result is taken.
// Reset clears all line state, the pair count and the sticky overflow flag,
// and sets max_pairs to 65536. After the final byte of a buffer the same
// state returns to its reset value, max_pairs excepted.
module ini_key_value_line_parser import ikv_pkg::*; (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             max_pairs_we_i,
  input  wire logic [CNT_W-1:0] max_pairs_i,
  ikv_in_if.sink                in_i,
  ikv_out_if.source             out_o
);

  logic              in_valid_q;
  logic [BYTE_W-1:0] in_data_q;
  logic              in_last_q;
  logic              can_move;
  logic              step;

  logic [CNT_W-1:0] max_pairs_q;

  logic [POS_W-1:0] byte_pos_q, byte_pos_d;
  phase_e           phase_q, phase_d;
  logic [POS_W-1:0] line_first_q, line_first_d;
  logic [POS_W-1:0] lln_q, lln_d;
  logic [POS_W-1:0] eq_pos_q, eq_pos_d;
  logic [POS_W-1:0] key_last_q, key_last_d;
  logic [POS_W-1:0] val_first_q, val_first_d;
  logic             seen_eq_q, seen_eq_d;
  logic [POS_W-1:0] br_pos_q, br_pos_d;
  logic             seen_br_q, seen_br_d;
  logic [POS_W-1:0] sec_start_q, sec_start_d;
  logic [POS_W-1:0] sec_len_q, sec_len_d;
  logic [CNT_W-1:0] pairs_q, pairs_d;
  logic             ovf_q, ovf_d;

  logic             blank;
  logic             line_end;
  logic [POS_W:0]   sec_s, sec_e, sec_l;
  logic             emit;
  kind_e            res_kind;
  logic [POS_W-1:0] res_ks, res_kl, res_vs, res_vl;
  logic [POS_W-1:0] res_sec_start, res_sec_len;
  logic [CNT_W-1:0] res_pairs;
  logic             res_ovf;

  logic             out_valid_q;
  kind_e            out_kind_q;
  logic [POS_W-1:0] out_sec_start_q, out_sec_len_q;
  logic [POS_W-1:0] out_ks_q, out_kl_q, out_vs_q, out_vl_q;
  logic [CNT_W-1:0] out_pairs_q;
  logic             out_final_q, out_ovf_q;

  assign can_move   = !out_valid_q || out_o.ready;
  assign step       = in_valid_q && can_move;
  assign in_i.ready = !in_valid_q || can_move;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      in_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.ready && in_i.valid) begin
      in_data_q <= in_i.data_byte;
      in_last_q <= in_i.is_last;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_pairs_q <= MAX_PAIRS_RST;
    end else if (max_pairs_we_i) begin
      max_pairs_q <= max_pairs_i;
    end
  end

  always_comb begin
    byte_pos_d   = byte_pos_q;
    phase_d      = phase_q;
    line_first_d = line_first_q;
    lln_d        = lln_q;
    eq_pos_d     = eq_pos_q;
    key_last_d   = key_last_q;
    val_first_d  = val_first_q;
    seen_eq_d    = seen_eq_q;
    br_pos_d     = br_pos_q;
    seen_br_d    = seen_br_q;
    sec_start_d  = sec_start_q;
    sec_len_d    = sec_len_q;
    pairs_d      = pairs_q;
    ovf_d        = ovf_q;
    emit         = 1'b0;
    res_kind     = KIND_PAIR;
    res_ks       = '0;
    res_kl       = '0;
    res_vs       = '0;
    res_vl       = '0;
    sec_s        = '0;
    sec_e        = '0;
    sec_l        = '0;

    blank    = is_blank(in_data_q);
    line_end = (in_data_q == CH_LF) || in_last_q;

    if (!blank) begin
      unique case (phase_q)
        PH_START: begin
          line_first_d = byte_pos_q;
          lln_d        = byte_pos_q;
          if (in_data_q == CH_HASH) begin
            phase_d = PH_COMMENT;
          end else if (in_data_q == CH_LBR) begin
            phase_d   = PH_SECTION;
            seen_br_d = 1'b0;
          end else begin
            phase_d   = PH_KV;
            seen_eq_d = 1'b0;
            if (in_data_q == CH_EQ) begin
              seen_eq_d = 1'b1;
              eq_pos_d  = byte_pos_q;
            end else begin
              key_last_d = byte_pos_q;
            end
          end
        end
        PH_SECTION: begin
          lln_d = byte_pos_q;
          if (in_data_q == CH_RBR && !seen_br_q) begin
            seen_br_d = 1'b1;
            br_pos_d  = byte_pos_q;
          end
        end
        PH_KV: begin
          if (seen_eq_q) begin
            if (lln_q == eq_pos_q) begin
              val_first_d = byte_pos_q;
            end
          end else if (in_data_q == CH_EQ) begin
            seen_eq_d = 1'b1;
            eq_pos_d  = byte_pos_q;
          end else begin
            key_last_d = byte_pos_q;
          end
          lln_d = byte_pos_q;
        end
        default: begin
        end
      endcase
    end

    if (line_end) begin
      if (phase_d == PH_SECTION) begin
        sec_s = {1'b0, line_first_d} + 1'b1;
        sec_e = seen_br_d ? {1'b0, br_pos_d} : ({1'b0, lln_d} + 1'b1);
        sec_l = (sec_e > sec_s) ? (sec_e - sec_s) : '0;
        sec_start_d = (sec_l != '0) ? sec_s[POS_W-1:0] : '0;
        sec_len_d   = sec_l[POS_W-1:0];
      end else if (phase_d == PH_KV) begin
        emit = 1'b1;
        if (!seen_eq_d) begin
          res_kind = KIND_NO_EQ;
        end else begin
          if (eq_pos_d != line_first_d && key_last_d >= line_first_d) begin
            res_ks = line_first_d;
            res_kl = key_last_d - line_first_d + 1'b1;
          end
          if (lln_d > eq_pos_d && lln_d >= val_first_d) begin
            res_vs = val_first_d;
            res_vl = lln_d - val_first_d + 1'b1;
          end
          if (pairs_q < max_pairs_q) begin
            res_kind = KIND_PAIR;
            if (pairs_q != CNT_SAT) begin
              pairs_d = pairs_q + 1'b1;
            end
          end else begin
            res_kind = KIND_DROP;
          end
        end
      end
      if (!emit && in_last_q) begin
        emit     = 1'b1;
        res_kind = KIND_END;
      end
      phase_d   = PH_START;
      seen_eq_d = 1'b0;
      seen_br_d = 1'b0;
    end

    if (!in_last_q) begin
      if (byte_pos_q < POS_LIMIT) begin
        byte_pos_d = byte_pos_q + 1'b1;
      end else begin
        ovf_d = 1'b1;
      end
    end

    res_sec_start = sec_start_d;
    res_sec_len   = sec_len_d;
    res_pairs     = pairs_d;
    res_ovf       = ovf_d;

    if (in_last_q) begin
      byte_pos_d   = '0;
      phase_d      = PH_START;
      line_first_d = '0;
      lln_d        = '0;
      eq_pos_d     = '0;
      key_last_d   = '0;
      val_first_d  = '0;
      seen_eq_d    = 1'b0;
      br_pos_d     = '0;
      seen_br_d    = 1'b0;
      sec_start_d  = '0;
      sec_len_d    = '0;
      pairs_d      = '0;
      ovf_d        = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byte_pos_q   <= '0;
      phase_q      <= PH_START;
      line_first_q <= '0;
      lln_q        <= '0;
      eq_pos_q     <= '0;
      key_last_q   <= '0;
      val_first_q  <= '0;
      seen_eq_q    <= 1'b0;
      br_pos_q     <= '0;
      seen_br_q    <= 1'b0;
      sec_start_q  <= '0;
      sec_len_q    <= '0;
      pairs_q      <= '0;
      ovf_q        <= 1'b0;
    end else if (step) begin
      byte_pos_q   <= byte_pos_d;
      phase_q      <= phase_d;
      line_first_q <= line_first_d;
      lln_q        <= lln_d;
      eq_pos_q     <= eq_pos_d;
      key_last_q   <= key_last_d;
      val_first_q  <= val_first_d;
      seen_eq_q    <= seen_eq_d;
      br_pos_q     <= br_pos_d;
      seen_br_q    <= seen_br_d;
      sec_start_q  <= sec_start_d;
      sec_len_q    <= sec_len_d;
      pairs_q      <= pairs_d;
      ovf_q        <= ovf_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (can_move) begin
      out_valid_q <= step && emit;
    end
  end

  // hold the result while the receiver stalls
  always_ff @(posedge clk_i) begin
    if (step && emit) begin
      out_kind_q      <= res_kind;
      out_sec_start_q <= res_sec_start;
      out_sec_len_q   <= res_sec_len;
      out_ks_q        <= res_ks;
      out_kl_q        <= res_kl;
      out_vs_q        <= res_vs;
      out_vl_q        <= res_vl;
      out_pairs_q     <= res_pairs;
      out_final_q     <= in_last_q;
      out_ovf_q       <= res_ovf;
    end
  end

  assign out_o.valid         = out_valid_q;
  assign out_o.kind          = out_kind_q;
  assign out_o.section_start = out_sec_start_q;
  assign out_o.section_len   = out_sec_len_q;
  assign out_o.key_start     = out_ks_q;
  assign out_o.key_len       = out_kl_q;
  assign out_o.value_start   = out_vs_q;
  assign out_o.value_len     = out_vl_q;
  assign out_o.pair_count    = out_pairs_q;
  assign out_o.is_final      = out_final_q;
  assign out_o.too_long      = out_ovf_q;

endmodule

`default_nettype wire
